// ----- hdl/bdda_pkg.sv -----
// shared types, constants and calendar functions for the business-day date advance
package bdda_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 12;
	localparam int WDAY_W  = 3;

	// walk year carries one extra bit so the weekday sees the unwrapped year
	localparam int WALK_YEAR_W = YEAR_W + 1;

	// floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
	localparam logic [12:0] RECIP_100       = 13'd5243;
	localparam int          RECIP_100_SHIFT = 19;
	localparam int          PROD100_W       = 27;

	// floor(s / 7) == (s * 37450) >> 18 for every weekday sum below 2^15
	localparam logic [15:0] RECIP_7       = 16'd37450;
	localparam int          RECIP_7_SHIFT = 18;
	localparam int          SUM_W         = 15;
	localparam int          PROD7_W       = 31;

	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

	localparam logic [WDAY_W-1:0] FRIDAY   = 3'd5;
	localparam logic [WDAY_W-1:0] SATURDAY = 3'd6;

	localparam logic [8:0] YEAR_CYCLE_LAST = 9'd399;

	typedef struct packed {
		logic load;       // capture a new start date
		logic mul_y;      // scale the march-based year by 1/100
		logic mul_yr;     // scale the calendar year by 1/100
		logic form_sum;   // weekday sum before reduction
		logic mul_sum;    // scale the sum by 1/7
		logic set_cycle;  // year position in the 400-year cycle
		logic resolve;    // weekday and date check
		logic step;       // advance one calendar day
	} dp_cmd_t;

	typedef struct packed {
		logic finish;     // bad date, or count used up
	} dp_status_t;

	function automatic logic is_leap(input logic [8:0] y400);
		is_leap = (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
			&& (y400 != 9'd300);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
		input logic leap);
		unique case (mo)
			4'd2:                    month_len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
			default:                 month_len = 5'd31;
		endcase
	endfunction

	// (31 * m) / 12 with the march-based month m of the weekday formula
	function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] mo);
		unique case (mo)
			4'd0:    month_term = 6'd25;
			4'd1:    month_term = 6'd28;
			4'd2:    month_term = 6'd31;
			4'd3:    month_term = 6'd2;
			4'd4:    month_term = 6'd5;
			4'd5:    month_term = 6'd7;
			4'd6:    month_term = 6'd10;
			4'd7:    month_term = 6'd12;
			4'd8:    month_term = 6'd15;
			4'd9:    month_term = 6'd18;
			4'd10:   month_term = 6'd20;
			4'd11:   month_term = 6'd23;
			4'd12:   month_term = 6'd25;
			4'd13:   month_term = 6'd28;
			4'd14:   month_term = 6'd31;
			default: month_term = 6'd33;
		endcase
	endfunction

endpackage

// ----- hdl/business_day_date_advance.sv -----
// sequence: a start transfer loads the date, then setup states PREP1 to PREP4 find the start
// weekday, the walk covers D calendar days (D = 0..~5733), and done rises in ST_DONE
// the walk steps one calendar day per cycle
// throughput: one item at a time; a new start transfer is taken only back in idle, after done
// done marks the result for one cycle only; the receiver cannot stall it
// reset: arst_n clears the sequencer to idle; date and count registers are not reset
module business_day_date_advance (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	output logic                            done,
	input  logic [bdda_pkg::YEAR_W-1:0]     start_year,
	input  logic [bdda_pkg::MONTH_W-1:0]    start_month,
	input  logic [bdda_pkg::DAY_W-1:0]      start_day,
	input  logic [bdda_pkg::COUNT_W-1:0]    business_days,
	output logic [bdda_pkg::YEAR_W-1:0]     return_year,
	output logic [bdda_pkg::MONTH_W-1:0]    return_month,
	output logic [bdda_pkg::DAY_W-1:0]      return_day,
	output logic [bdda_pkg::WDAY_W-1:0]     return_weekday,
	output logic                            bad_date
);

	// command and status between the sequencer and the datapath
	bdda_pkg::dp_cmd_t    cmd;
	bdda_pkg::dp_status_t status;

	// sequencer: load, weekday setup (two 1/100 scalings, sum, 1/7 scaling, year cycle position,
	// weekday and date check), then one day per cycle until the count is used up or the date is bad
	bdda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: the working registers double as the result registers, so the
	// result holds still through the done cycle
	bdda_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.business_days (business_days),
		.status        (status),
		.year          (return_year),
		.month         (return_month),
		.day           (return_day),
		.weekday       (return_weekday),
		.bad           (bad_date)
	);

endmodule

// ----- hdl/bdda_ctrl.sv -----
// sequencing state machine: setup steps, day walk and result strobe
module bdda_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  bdda_pkg::dp_status_t  status,
	output bdda_pkg::dp_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP1 = 3'd1;
	localparam logic [2:0] ST_PREP2 = 3'd2;
	localparam logic [2:0] ST_PREP3 = 3'd3;
	localparam logic [2:0] ST_PREP4 = 3'd4;
	localparam logic [2:0] ST_WALK  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.mul_y  = 1'b1;
				state_next = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.form_sum = 1'b1;
				cmd.mul_yr   = 1'b1;
				state_next   = ST_PREP3;
			end
			ST_PREP3: begin
				cmd.mul_sum   = 1'b1;
				cmd.set_cycle = 1'b1;
				state_next    = ST_PREP4;
			end
			ST_PREP4: begin
				cmd.resolve = 1'b1;
				state_next  = ST_WALK;
			end
			ST_WALK: begin
				if (status.finish) begin
					state_next = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ----- hdl/bdda_datapath.sv -----
// date, count and weekday registers with the setup arithmetic and the day stepper
module bdda_datapath (
	input  logic                               clk,
	input  bdda_pkg::dp_cmd_t                  cmd,
	input  logic [bdda_pkg::YEAR_W-1:0]        start_year,
	input  logic [bdda_pkg::MONTH_W-1:0]       start_month,
	input  logic [bdda_pkg::DAY_W-1:0]         start_day,
	input  logic [bdda_pkg::COUNT_W-1:0]       business_days,
	output bdda_pkg::dp_status_t               status,
	output logic [bdda_pkg::YEAR_W-1:0]        year,
	output logic [bdda_pkg::MONTH_W-1:0]       month,
	output logic [bdda_pkg::DAY_W-1:0]         day,
	output logic [bdda_pkg::WDAY_W-1:0]        weekday,
	output logic                               bad
);

	logic [bdda_pkg::WALK_YEAR_W-1:0] year_q;
	logic [bdda_pkg::MONTH_W-1:0]     month_q;
	logic [bdda_pkg::DAY_W-1:0]       day_q;
	logic [bdda_pkg::COUNT_W-1:0]     cnt_q;
	logic [bdda_pkg::WDAY_W-1:0]      wd_q;
	logic [8:0]                       y400_q;
	logic                             bad_q;
	logic [bdda_pkg::YEAR_W-1:0]      ysub_q;
	logic                             neg_q;
	logic [bdda_pkg::PROD100_W-1:0]   prod_q;
	logic [bdda_pkg::SUM_W-1:0]       sum_q;
	logic [bdda_pkg::PROD7_W-1:0]     prod7_q;

	logic                             march_shift;
	logic [bdda_pkg::YEAR_W-1:0]      mul_a;
	logic [7:0]                       q100;
	logic [5:0]                       q400;
	logic [bdda_pkg::YEAR_W-1:0]      ypart;
	logic [bdda_pkg::SUM_W-1:0]       sum_next;
	logic [bdda_pkg::YEAR_W-1:0]      y400_full;
	logic [12:0]                      q7;
	logic [bdda_pkg::SUM_W-1:0]       rem_raw;
	logic [bdda_pkg::SUM_W-1:0]       rem_fix;
	logic                             leap;
	logic [bdda_pkg::DAY_W-1:0]       mlen;
	logic                             last_day;
	logic                             workday;
	logic                             hold_wd;

	// january and february count as months of the previous year
	assign march_shift = (start_month <= bdda_pkg::FEBRUARY);

	assign mul_a = cmd.mul_y ? ypart : year_q[bdda_pkg::YEAR_W-1:0];
	assign q100  = prod_q[bdda_pkg::PROD100_W-1:bdda_pkg::RECIP_100_SHIFT];
	assign q400  = q100[7:2];

	// year zero before march gives y = -1: its terms truncate to -1, i.e. 6 mod 7
	assign ypart    = neg_q ? '0 : ysub_q;
	assign sum_next = bdda_pkg::SUM_W'(day_q) + bdda_pkg::SUM_W'(ypart)
		+ bdda_pkg::SUM_W'(ypart >> 2) + bdda_pkg::SUM_W'(q400)
		+ bdda_pkg::SUM_W'(bdda_pkg::month_term(month_q))
		+ (neg_q ? bdda_pkg::SUM_W'(6) : '0) - bdda_pkg::SUM_W'(q100);

	assign y400_full = year_q[bdda_pkg::YEAR_W-1:0]
		- (bdda_pkg::YEAR_W'(q400) * bdda_pkg::YEAR_W'(400));

	assign q7      = prod7_q[bdda_pkg::PROD7_W-1:bdda_pkg::RECIP_7_SHIFT];
	assign rem_raw = sum_q - (bdda_pkg::SUM_W'(q7) * bdda_pkg::SUM_W'(7));
	assign rem_fix = (rem_raw >= bdda_pkg::SUM_W'(7)) ? rem_raw - bdda_pkg::SUM_W'(7)
		: rem_raw;

	assign leap     = bdda_pkg::is_leap(y400_q);
	assign mlen     = bdda_pkg::month_len(month_q, leap);
	assign last_day = (day_q == mlen);
	assign workday  = (wd_q != bdda_pkg::FRIDAY) && (wd_q != bdda_pkg::SATURDAY);
	// year zero: the formula gives february 29 and march 1 the same weekday
	assign hold_wd  = (year_q == '0) && (month_q == bdda_pkg::FEBRUARY) && last_day;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= {1'b0, start_year};
			month_q <= start_month;
			day_q   <= start_day;
			cnt_q   <= business_days;
			neg_q   <= march_shift && (start_year == '0);
			ysub_q  <= march_shift ? start_year - bdda_pkg::YEAR_W'(1) : start_year;
		end
		if (cmd.mul_y || cmd.mul_yr) begin
			prod_q <= bdda_pkg::PROD100_W'(mul_a) * bdda_pkg::PROD100_W'(bdda_pkg::RECIP_100);
		end
		if (cmd.form_sum) begin
			sum_q <= sum_next;
		end
		if (cmd.mul_sum) begin
			prod7_q <= bdda_pkg::PROD7_W'(sum_q) * bdda_pkg::PROD7_W'(bdda_pkg::RECIP_7);
		end
		if (cmd.set_cycle) begin
			y400_q <= y400_full[8:0];
		end
		if (cmd.resolve) begin
			wd_q  <= rem_fix[bdda_pkg::WDAY_W-1:0];
			bad_q <= (month_q == '0) || (month_q > bdda_pkg::DECEMBER) || (day_q > mlen);
		end
		if (cmd.step) begin
			if (workday) begin
				cnt_q <= cnt_q - bdda_pkg::COUNT_W'(1);
			end
			if (!hold_wd) begin
				wd_q <= (wd_q == bdda_pkg::SATURDAY) ? '0 : wd_q + bdda_pkg::WDAY_W'(1);
			end
			if (last_day) begin
				day_q <= bdda_pkg::DAY_W'(1);
				if (month_q == bdda_pkg::DECEMBER) begin
					month_q <= bdda_pkg::JANUARY;
					year_q  <= year_q + bdda_pkg::WALK_YEAR_W'(1);
					y400_q  <= (y400_q == bdda_pkg::YEAR_CYCLE_LAST) ? '0 : y400_q + 9'd1;
				end else begin
					month_q <= month_q + bdda_pkg::MONTH_W'(1);
				end
			end else begin
				day_q <= day_q + bdda_pkg::DAY_W'(1);
			end
		end
	end

	assign status.finish = bad_q || (cnt_q == '0);

	assign year    = year_q[bdda_pkg::YEAR_W-1:0];
	assign month   = month_q;
	assign day     = day_q;
	assign weekday = wd_q;
	assign bad     = bad_q;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the business-day date advance block
`timescale 1ns / 100ps

module tb;

	// one result as the block reports it
	typedef struct packed {
		logic [bdda_pkg::YEAR_W-1:0]  year;
		logic [bdda_pkg::MONTH_W-1:0] month;
		logic [bdda_pkg::DAY_W-1:0]   day;
		logic [bdda_pkg::WDAY_W-1:0]  wday;
		logic                         bad;
	} date_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic                           done;
	logic [bdda_pkg::YEAR_W-1:0]    start_year;
	logic [bdda_pkg::MONTH_W-1:0]   start_month;
	logic [bdda_pkg::DAY_W-1:0]     start_day;
	logic [bdda_pkg::COUNT_W-1:0]   business_days;
	logic [bdda_pkg::YEAR_W-1:0]    return_year;
	logic [bdda_pkg::MONTH_W-1:0]   return_month;
	logic [bdda_pkg::DAY_W-1:0]     return_day;
	logic [bdda_pkg::WDAY_W-1:0]    return_weekday;
	logic                           bad_date;

	// dates predicted for transfers already accepted, oldest first
	date_result_t pending_dates[$];

	int mismatches    = 0;
	int dates_sent    = 0;
	int dates_checked = 0;
	int bad_starts    = 0;
	int longest_count = 0;
	int burst_left    = 0;

	business_day_date_advance u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.done           (done),
		.start_year     (start_year),
		.start_month    (start_month),
		.start_day      (start_day),
		.business_days  (business_days),
		.return_year    (return_year),
		.return_month   (return_month),
		.return_day     (return_day),
		.return_weekday (return_weekday),
		.bad_date       (bad_date)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// month length with the gregorian leap rule; months outside 1..12 count as 31 days
	function automatic int days_in_month(input int yr, input int mo);
		if (mo == bdda_pkg::FEBRUARY) begin
			if (yr % 400 == 0 || (yr % 4 == 0 && yr % 100 != 0))
				return 29;
			return 28;
		end
		if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
			return 30;
		return 31;
	endfunction

	// march-based weekday sum, 0 sunday; division truncates toward zero so year zero
	// in january and february works with y = -1
	function automatic int day_of_week(input int yr, input int mo, input int dy);
		int a;
		int y;
		int m;
		int s;
		int r;
		a = (14 - mo) / 12;
		y = yr - a;
		m = mo + 12 * a - 2;
		s = dy + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12;
		r = s % 7;
		if (r < 0)
			r += 7;
		return r;
	endfunction

	// walk the calendar one day at a time, spending one count per non-weekend day;
	// the year is kept unwrapped so the weekday of the reached date stays right
	function automatic date_result_t advance_business_days(input int yr, input int mo,
		input int dy, input int cnt);
		date_result_t r;
		int wd;
		r.bad = (mo < 1 || mo > 12 || dy > days_in_month(yr, mo));
		if (!r.bad) begin
			while (cnt > 0) begin
				wd = day_of_week(yr, mo, dy);
				if (wd != bdda_pkg::FRIDAY && wd != bdda_pkg::SATURDAY)
					cnt--;
				if (dy == days_in_month(yr, mo)) begin
					dy = 1;
					if (mo == bdda_pkg::DECEMBER) begin
						mo = bdda_pkg::JANUARY;
						yr++;
					end else begin
						mo++;
					end
				end else begin
					dy++;
				end
			end
		end
		wd = day_of_week(yr, mo, dy);
		r.year  = yr[bdda_pkg::YEAR_W-1:0];
		r.month = mo[bdda_pkg::MONTH_W-1:0];
		r.day   = dy[bdda_pkg::DAY_W-1:0];
		r.wday  = wd[bdda_pkg::WDAY_W-1:0];
		return r;
	endfunction

	// one start transfer; the sender runs in bursts, dropping start for a random gap
	// between them, and start stays high from one item to the next inside a burst
	task automatic send_date(input int yr, input int mo, input int dy, input int cnt);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// about one burst in four is a long stretch with no idling at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
				: $urandom_range(1, 5);
		end
		burst_left--;
		start         <= 1'b1;
		start_year    <= yr[bdda_pkg::YEAR_W-1:0];
		start_month   <= mo[bdda_pkg::MONTH_W-1:0];
		start_day     <= dy[bdda_pkg::DAY_W-1:0];
		business_days <= cnt[bdda_pkg::COUNT_W-1:0];
		// busy read here is its value before this edge, so low means the transfer happened
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(advance_business_days(yr, mo, dy, cnt));
		dates_sent++;
		if (cnt > longest_count)
			longest_count = cnt;
	endtask

	// results are checked in order against the oldest prediction
	always @(posedge clk) begin
		date_result_t exp_date;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with no transfer waiting: %0d-%0d-%0d wd %0d bad %0b",
						$realtime, return_year, return_month, return_day, return_weekday,
						bad_date);
			end else begin
				exp_date = pending_dates.pop_front();
				dates_checked++;
				if (exp_date.bad)
					bad_starts++;
				if (return_year !== exp_date.year || return_month !== exp_date.month
					|| return_day !== exp_date.day || return_weekday !== exp_date.wday
					|| bad_date !== exp_date.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] date %0d: expected %0d-%0d-%0d wd %0d bad %0b, got %0d-%0d-%0d wd %0d bad %0b",
							$realtime, dates_checked, exp_date.year, exp_date.month,
							exp_date.day, exp_date.wday, exp_date.bad, return_year,
							return_month, return_day, return_weekday, bad_date);
				end
			end
		end
	end

	// a count of zero hands back the start date as it is
	task automatic test_zero_count();
		send_date(2024, 3, 15, 0);
		send_date(1, 1, 1, 0);
	endtask

	// day past month end and months outside 1..12 are flagged, start date echoed
	task automatic test_bad_start_dates();
		send_date(2023, 2, 29, 10);
		send_date(2023, 4, 31, 1);
		send_date(2024, 0, 31, 5);
		send_date(2024, 13, 1, 5);
		send_date(1999, 14, 12, 0);
		// every input bit high: month fifteen is rejected
		send_date(16383, 15, 31, 4095);
	endtask

	// day zero acts as the day before the first; year zero is a leap year
	task automatic test_day_and_year_zero();
		send_date(2024, 5, 0, 3);
		send_date(0, 1, 1, 2);
		send_date(0, 2, 29, 1);
		send_date(0, 1, 0, 4);
	endtask

	// century leap rule and month and year rollover
	task automatic test_leap_and_rollover();
		send_date(1900, 2, 28, 1);
		send_date(2000, 2, 28, 2);
		send_date(2023, 12, 31, 1);
		send_date(2024, 1, 31, 1);
		// the last year the field holds wraps to zero on the way
		send_date(16383, 12, 31, 5);
	endtask

	// starting on a weekend day (friday or saturday) skips it before the count moves; a sunday start counts at once
	task automatic test_weekend_starts();
		send_date(2024, 3, 15, 1);
		send_date(2024, 3, 16, 1);
		send_date(2024, 3, 17, 5);
	endtask

	// the longest walks the count allows
	task automatic test_largest_counts();
		send_date(1, 1, 1, 4095);
		send_date(9999, 12, 31, 4095);
		send_date(16383, 12, 31, 4095);
	endtask

	// mostly valid dates with random content; some bad months, day zero and days past
	// month end mixed in, and a few long counts among many short ones
	task automatic test_random_dates(input int num_dates);
		int yr;
		int mo;
		int dy;
		int cnt;
		int dim;
		repeat (num_dates) begin
			case ($urandom_range(0, 9))
				0:       yr = 0;
				1:       yr = $urandom_range(16370, 16383);
				2:       yr = $urandom_range(0, 16383);
				3:       yr = 100 * $urandom_range(0, 99) + $urandom_range(0, 3);
				default: yr = $urandom_range(1, 9999);
			endcase
			case ($urandom_range(0, 19))
				0:       mo = 0;
				1:       mo = $urandom_range(13, 15);
				default: mo = $urandom_range(1, 12);
			endcase
			dim = days_in_month(yr, mo);
			case ($urandom_range(0, 19))
				0:       dy = 0;
				1:       dy = $urandom_range(dim, 31);
				2, 3:    dy = dim;
				default: dy = $urandom_range(1, dim);
			endcase
			case ($urandom_range(0, 24))
				0:          cnt = $urandom_range(3000, 4095);
				1:          cnt = $urandom_range(0, 4095);
				2, 3, 4:    cnt = $urandom_range(40, 600);
				5:          cnt = 0;
				default:    cnt = $urandom_range(1, 40);
			endcase
			send_date(yr, mo, dy, cnt);
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		start_year    <= '0;
		start_month   <= '0;
		start_day     <= '0;
		business_days <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_count();
		test_bad_start_dates();
		test_day_and_year_zero();
		test_leap_and_rollover();
		test_weekend_starts();
		test_largest_counts();
		test_random_dates(100);

		start <= 1'b0;
		// the wait bound lies well beyond the longest walk from transfer to done
		wait_cycles = 0;
		while (pending_dates.size() != 0 && wait_cycles < 12000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (pending_dates.size() != 0) begin
			mismatches += pending_dates.size();
			$display("%0d dates never came back", pending_dates.size());
		end

		$display("ran %0d start transfers, %0d results checked, %0d of them flagged bad",
			dates_sent, dates_checked, bad_starts);
		$display("longest count %0d business days, %0d mismatches", longest_count,
			mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
